// ----- hdl/mm4_pkg.sv -----
package mm4_pkg;

  // Matrix geometry and number format
  localparam int DIM       = 4;
  localparam int DIM_W     = $clog2(DIM);
  localparam int NELEM     = DIM * DIM;
  localparam int IDX_W     = 2 * DIM_W;
  localparam int CNT_W     = 3 * DIM_W;
  localparam int DATA_W    = 32;
  localparam int ACC_W     = 64;
  localparam int FRAC_BITS = 16;
  localparam int REQ_W     = 2;

  // Request codes; code 3 is unused and dropped
  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD_A  = 2'd0,
    REQ_LOAD_B  = 2'd1,
    REQ_COMPUTE = 2'd2
  } req_t;

  // Control that travels alongside one multiply-accumulate step
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] elem;
  } mm4_tag_t;

endpackage

// ----- hdl/mm4_if.sv -----
interface mm4_in_if;
  logic                          valid;
  logic                          ready;
  logic [mm4_pkg::REQ_W-1:0]     req_type;
  logic [mm4_pkg::IDX_W-1:0]     elem_index;
  logic signed [mm4_pkg::DATA_W-1:0] elem_value;

  modport source (output valid, req_type, elem_index, elem_value, input ready);
  modport sink   (input valid, req_type, elem_index, elem_value, output ready);
endinterface

interface mm4_out_if;
  logic                          valid;
  logic                          ready;
  logic [mm4_pkg::IDX_W-1:0]     out_index;
  logic signed [mm4_pkg::DATA_W-1:0] out_value;
  logic                          saturated;
  logic                          is_last;

  modport source (output valid, out_index, out_value, saturated, is_last, input ready);
  modport sink   (input valid, out_index, out_value, saturated, is_last, output ready);
endinterface

// ----- hdl/matrix4x4_multiply_top.sv -----
// 4x4 fixed-point (Q16.16) matrix multiplier, matrices column-major. A load
// word (req_type 0 for A, 1 for B) writes one element; both stores read as
// zero after reset. A compute word streams out the 16 elements of A times B
// in column-major order, is_last on the final one, each sum clipped to 32
// bits with saturated set when clipped. A compute issues 64 steps of
// multiply-accumulate, one per cycle (bounded by the single read port of
// each store) unless output back-pressure stalls the whole pipeline. The
// input is not ready while a compute is issuing reads, so a load or
// compute word is taken once the previous compute has finished issuing.
module matrix4x4_multiply_top (
  input logic         clk,
  input logic         rst_n,
  mm4_in_if.sink      in_if,
  mm4_out_if.source   out_if
);
  import mm4_pkg::*;

  logic             run_r;
  logic [CNT_W-1:0] cnt_r;
  logic             adv;
  logic             in_acc;
  logic             load_a;
  logic             load_b;
  logic             issue;
  logic [DIM_W-1:0] seq_c;
  logic [DIM_W-1:0] seq_r;
  logic [DIM_W-1:0] seq_k;
  logic [IDX_W-1:0] a_addr;
  logic [IDX_W-1:0] b_addr;
  logic [DATA_W-1:0] a_data;
  logic [DATA_W-1:0] b_data;
  mm4_tag_t         s1_tag_r;
  mm4_tag_t         s1_tag_nxt;
  mm4_tag_t         fin_tag;
  logic [ACC_W-1:0] fin_sum;
  logic             sat_hi;
  logic             sat_lo;
  logic [DATA_W-1:0] clip_val;

  logic              out_valid_r;
  logic [IDX_W-1:0]  out_index_r;
  logic [DATA_W-1:0] out_value_r;
  logic              out_sat_r;
  logic              out_last_r;

  // Stall everything while a result waits and the sink holds off
  assign adv    = !out_valid_r || out_if.ready;
  assign in_acc = in_if.valid && in_if.ready;
  assign load_a = in_acc && (in_if.req_type == REQ_LOAD_A);
  assign load_b = in_acc && (in_if.req_type == REQ_LOAD_B);
  assign issue  = run_r && adv;

  assign in_if.ready = !run_r;

  // Sequence column, row and inner index
  assign seq_c  = cnt_r[CNT_W-1 -: DIM_W];
  assign seq_r  = cnt_r[DIM_W +: DIM_W];
  assign seq_k  = cnt_r[DIM_W-1:0];
  assign a_addr = {seq_k, seq_r};
  assign b_addr = {seq_c, seq_k};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (in_acc && (in_if.req_type == REQ_COMPUTE)) begin
      run_r <= 1'b1;
      cnt_r <= '0;
    end else if (issue) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NELEM * DIM - 1)) begin
        run_r <= 1'b0;
      end
    end
  end

  // Tag the read issued this cycle
  always_comb begin
    s1_tag_nxt.valid = issue;
    s1_tag_nxt.first = (seq_k == '0);
    s1_tag_nxt.last  = (seq_k == DIM_W'(DIM - 1));
    s1_tag_nxt.elem  = {seq_c, seq_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r <= '0;
    end else if (adv) begin
      s1_tag_r <= s1_tag_nxt;
    end
  end

  mm4_store u_store_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (load_a),
    .wr_addr (in_if.elem_index),
    .wr_data (in_if.elem_value),
    .rd_en   (adv),
    .rd_addr (a_addr),
    .rd_data (a_data)
  );

  mm4_store u_store_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (load_b),
    .wr_addr (in_if.elem_index),
    .wr_data (in_if.elem_value),
    .rd_en   (adv),
    .rd_addr (b_addr),
    .rd_data (b_data)
  );

  mm4_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .s1_tag  (s1_tag_r),
    .a_data  (a_data),
    .b_data  (b_data),
    .fin_tag (fin_tag),
    .fin_sum (fin_sum)
  );

  // Clip the 64-bit sum to 32 bits
  assign sat_hi = !fin_sum[ACC_W-1] && (fin_sum[ACC_W-2:DATA_W-1] != '0);
  assign sat_lo =  fin_sum[ACC_W-1] && (fin_sum[ACC_W-2:DATA_W-1] != '1);

  always_comb begin
    if (sat_hi) begin
      clip_val = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (sat_lo) begin
      clip_val = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      clip_val = fin_sum[DATA_W-1:0];
    end
  end

  // Output register; drop the word once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fin_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && fin_tag.valid) begin
      out_index_r <= fin_tag.elem;
      out_value_r <= clip_val;
      out_sat_r   <= sat_hi || sat_lo;
      out_last_r  <= (fin_tag.elem == IDX_W'(NELEM - 1));
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.out_index = out_index_r;
  assign out_if.out_value = out_value_r;
  assign out_if.saturated = out_sat_r;
  assign out_if.is_last   = out_last_r;

endmodule

// ----- hdl/mm4_store.sv -----
module mm4_store (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [mm4_pkg::IDX_W-1:0]    wr_addr,
  input  logic [mm4_pkg::DATA_W-1:0]   wr_data,
  input  logic                         rd_en,
  input  logic [mm4_pkg::IDX_W-1:0]    rd_addr,
  output logic [mm4_pkg::DATA_W-1:0]   rd_data
);
  import mm4_pkg::*;

  logic [DATA_W-1:0] mem [NELEM];
  logic [NELEM-1:0]  valid_r;
  logic [DATA_W-1:0] rd_data_r;

  // Write the array; entries carry no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Mark written entries; reset makes every entry read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Registered read; hold while the pipeline stalls
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/mm4_mac.sv -----
module mm4_mac (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  mm4_pkg::mm4_tag_t            s1_tag,
  input  logic [mm4_pkg::DATA_W-1:0]   a_data,
  input  logic [mm4_pkg::DATA_W-1:0]   b_data,
  output mm4_pkg::mm4_tag_t            fin_tag,
  output logic [mm4_pkg::ACC_W-1:0]    fin_sum
);
  import mm4_pkg::*;

  mm4_tag_t                 s2_tag_r;
  mm4_tag_t                 fin_tag_r;
  logic signed [ACC_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]  prod_nxt;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  shifted;
  logic [ACC_W-1:0]         sum_r;

  // Full-width signed product of two sign-extended elements
  assign prod_nxt = $signed({{(ACC_W-DATA_W){a_data[DATA_W-1]}}, a_data}) *
                    $signed({{(ACC_W-DATA_W){b_data[DATA_W-1]}}, b_data});

  // Scale each product back to the fixed-point grid, then add
  assign shifted = prod_r >>> FRAC_BITS;
  assign acc_nxt = (s2_tag_r.first ? '0 : acc_r) + shifted;

  // Advance control tags; the finished tag is valid only on an element's last step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_tag_r  <= '0;
      fin_tag_r <= '0;
    end else if (adv) begin
      s2_tag_r        <= s1_tag;
      fin_tag_r.valid <= s2_tag_r.valid && s2_tag_r.last;
      fin_tag_r.first <= s2_tag_r.first;
      fin_tag_r.last  <= s2_tag_r.last;
      fin_tag_r.elem  <= s2_tag_r.elem;
    end
  end

  // Multiply, accumulate and capture the finished sum
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      if (s2_tag_r.valid) begin
        acc_r <= acc_nxt;
      end
      if (s2_tag_r.valid && s2_tag_r.last) begin
        sum_r <= acc_nxt;
      end
    end
  end

  assign fin_tag = fin_tag_r;
  assign fin_sum = sum_r;

endmodule

// ----- hdl/mm4_check.sv -----
module mm4_check (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [mm4_pkg::REQ_W-1:0]   in_req_type,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [mm4_pkg::IDX_W-1:0]   out_index,
  input logic [mm4_pkg::DATA_W-1:0]  out_value,
  input logic                        out_saturated,
  input logic                        out_is_last
);
  import mm4_pkg::*;

  // A stalled result word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(out_value))
    else $error("result word changed while stalled");

  // The last flag marks only the final element
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_last == (out_index == IDX_W'(NELEM - 1))))
    else $error("is_last does not match the final element");

  // A clipped word sits at one of the range limits
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_value == {1'b0, {(DATA_W-1){1'b1}}}) ||
      (out_value == {1'b1, {(DATA_W-1){1'b0}}}))
    else $error("saturated word is not at a range limit");

  // A compute word closes the input while it issues
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == REQ_COMPUTE) |=> !in_ready)
    else $error("input ready right after a compute word");

endmodule

bind matrix4x4_multiply_top mm4_check u_mm4_check (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .in_req_type   (in_if.req_type),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_index     (out_if.out_index),
  .out_value     (out_if.out_value),
  .out_saturated (out_if.saturated),
  .out_is_last   (out_if.is_last)
);
